// ----- rtl/core/binomial_coefficient_unit_defines.svh -----
// ----------------------------------------------------------------------------
// binomial_coefficient_unit_defines.svh
// Assertion macros shared by the binomial coefficient unit.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define BCU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl failed");

// expression must never be true outside reset
`define BCU_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m: lbl failed");

`endif

// ----- rtl/core/bcu_pkg.sv -----
// ----------------------------------------------------------------------------
// bcu_pkg
// Types and constants of the binomial coefficient unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

	localparam int N_W     = 6;   // n_total / k_chosen width
	localparam int COEF_W  = 59;  // result width
	localparam int ACC_W   = 64;  // working value width
	localparam int N_MAX_D = 62;  // default saturation limit for n

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_START,
		S_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- rtl/core/bcu_div.sv -----
// ----------------------------------------------------------------------------
// bcu_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcu_div #(
	parameter int DW = bcu_pkg::ACC_W,
	parameter int VW = bcu_pkg::N_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        dividend,
	input  logic [VW-1:0]        divisor,
	output logic [DW-1:0]        quotient,
	output bcu_pkg::div_status_t status
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW+1:0]    trial;

	// shift in next dividend bit and try subtracting
	assign trial = {1'b0, rem_q, quo_q[DW-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial[VW+1]) begin
				rem_q <= {rem_q[VW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end else begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ----- rtl/core/binomial_coefficient_unit.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_unit
// Exact binomial coefficient C(n_total, k_chosen) with a shared divider.
// ----------------------------------------------------------------------------
// One transaction on the input side (n_total, k_chosen) yields exactly one
// transaction on the output side carrying C(n, k). n above N_MAX saturates to
// N_MAX; k above n gives 0; k is folded to n-k when that is smaller, and a
// folded k of 0 gives 1. Otherwise a 64-bit running value starts at n and for
// i = 2..k is multiplied by (n-i+1) in a 64x6 multiplier and divided exactly
// by i in the shared restoring divider (one quotient bit a cycle). Each round
// passes through S_CHECK, S_MUL, S_START and S_WAIT; a finished item then
// waits in S_DONE while out_ready holds back the previous result. in_ready
// is high only while the sequencer is idle; the result sits in an output
// register, so a new transaction can be taken while it waits for out_ready.
// ----------------------------------------------------------------------------
`include "binomial_coefficient_unit_defines.svh"

module binomial_coefficient_unit #(
	parameter int N_MAX = bcu_pkg::N_MAX_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bcu_pkg::N_W-1:0]    n_total,
	input  logic [bcu_pkg::N_W-1:0]    k_chosen,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bcu_pkg::COEF_W-1:0] coefficient
);

	localparam int NW = bcu_pkg::N_W;
	localparam int AW = bcu_pkg::ACC_W;
	localparam logic [NW-1:0] NMAX_C = NW'(N_MAX);

	bcu_pkg::state_t state_q, state_d;

	logic [NW-1:0]           n_q;     // saturated n
	logic [NW-1:0]           kf_q;    // folded k
	logic [NW-1:0]           i_q;     // round index
	logic [AW-1:0]           acc_q;   // running value
	logic [bcu_pkg::COEF_W-1:0] coef_q;
	logic                    out_valid_q;

	logic                    in_fire;
	logic                    out_free;
	logic [NW-1:0]           n_sat;
	logic [NW-1:0]           k_fold;
	logic [AW-1:0]           acc_init;
	logic [NW-1:0]           factor;
	logic [AW+NW-1:0]        product;
	logic [AW-1:0]           quotient;
	logic                    div_start;
	bcu_pkg::div_status_t    div_st;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// argument prep: saturate n, zero on k > n, fold k
	always_comb begin
		n_sat = (n_total > NMAX_C) ? NMAX_C : n_total;
		if (k_chosen > n_sat) begin
			k_fold   = '0;
			acc_init = '0;
		end else begin
			k_fold = ({1'b0, k_chosen, 1'b0} > {2'b00, n_sat}) ? (n_sat - k_chosen) : k_chosen;
			acc_init = (k_fold == '0) ? AW'(1) : AW'(n_sat);
		end
	end

	assign factor  = n_q - i_q + NW'(1);
	assign product = acc_q * factor;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcu_pkg::S_IDLE:  if (in_valid) state_d = bcu_pkg::S_CHECK;
			bcu_pkg::S_CHECK: state_d = (i_q > kf_q) ? bcu_pkg::S_DONE : bcu_pkg::S_MUL;
			bcu_pkg::S_MUL:   state_d = bcu_pkg::S_START;
			bcu_pkg::S_START: state_d = bcu_pkg::S_WAIT;
			bcu_pkg::S_WAIT:  if (div_st.done) state_d = bcu_pkg::S_CHECK;
			bcu_pkg::S_DONE:  if (out_free) state_d = bcu_pkg::S_IDLE;
			default:          state_d = bcu_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			bcu_pkg::S_IDLE:  in_ready  = 1'b1;
			bcu_pkg::S_START: div_start = 1'b1;
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcu_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bcu_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			n_q   <= n_sat;
			kf_q  <= k_fold;
			i_q   <= NW'(2);
			acc_q <= acc_init;
		end else if (state_q == bcu_pkg::S_MUL) begin
			acc_q <= product[AW-1:0];
		end else if (state_q == bcu_pkg::S_WAIT && div_st.done) begin
			acc_q <= quotient;
			i_q   <= i_q + NW'(1);
		end
		if (state_q == bcu_pkg::S_DONE && out_free) begin
			coef_q <= acc_q[bcu_pkg::COEF_W-1:0];
		end
	end

	bcu_div #(
		.DW(AW),
		.VW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (i_q),
		.quotient (quotient),
		.status   (div_st)
	);

	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;

	// divider is only kicked while idle
	`BCU_NEVER(a_div_start_idle, clk, arst_n, div_start && div_st.busy)
	// divider completion only seen while waiting on it
	`BCU_ASSERT(a_div_done_wait, clk, arst_n, div_st.done |-> state_q == bcu_pkg::S_WAIT)
	// a multiply round never runs past the folded k
	`BCU_ASSERT(a_round_range, clk, arst_n, state_q == bcu_pkg::S_MUL |-> (i_q >= NW'(2)) && (i_q <= kf_q))
	// accepted transaction starts the round check
	`BCU_ASSERT(a_accept_check, clk, arst_n, in_fire |=> state_q == bcu_pkg::S_CHECK)
	// pending result is not overwritten
	`BCU_ASSERT(a_out_hold, clk, arst_n, out_valid_q && !out_ready |=> $stable(coef_q) && out_valid_q)

endmodule

// ----- test/tb_binomial_coefficient_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binomial_coefficient_unit
// Self-checking bench for the n-choose-k unit.
// ----------------------------------------------------------------------------
// Drives (n_total, k_chosen) pairs over the input handshake and compares each
// coefficient with an independent computation of C(n, k). A directed set hits
// the corners (saturated n, k above n, k zero, k equal to n, the widest
// results), then random pairs follow, mostly with small n for fewer divide
// rounds. Both handshakes idle in random bursts except at the end.
// ----------------------------------------------------------------------------
module tb_binomial_coefficient_unit;

	localparam int NW           = bcu_pkg::N_W;
	localparam int CW           = bcu_pkg::COEF_W;
	localparam int AW           = bcu_pkg::ACC_W;
	localparam int N_LIMIT      = bcu_pkg::N_MAX_D;
	localparam int DIR_COUNT    = 25;
	localparam int RAND_COUNT   = 265;
	localparam int CALM_ITEMS   = 30;     // last items run without idling
	localparam int DRAIN_CYCLES = 200;    // settle time after the last result
	// worst item plus the longest output stall, with a wide margin
	localparam int HANG_LIMIT   = 12000;

	// ------------------------------------------------------------------------
	// Scoreboard: one expected coefficient per accepted input transaction,
	// matched in order against the output transactions.
	// ------------------------------------------------------------------------
	class coefficient_scoreboard;
		typedef struct {
			logic [NW-1:0] n;
			logic [NW-1:0] k;
			logic [CW-1:0] coef;
		} pending_t;

		pending_t expected_q[$];
		int       mismatches = 0;

		task report(string what);
			mismatches++;
			$display("ERROR @%0t: %s", $time, what);
		endtask

		// C(n, k) with n saturated to the unit's limit; k folded to the
		// smaller side so the running product stays within 64 bits
		function logic [CW-1:0] binomial(logic [NW-1:0] n_in, logic [NW-1:0] k_in);
			logic [AW-1:0] n;
			logic [AW-1:0] k;
			logic [AW-1:0] acc;
			logic [AW-1:0] i;
			n = AW'(n_in);
			k = AW'(k_in);
			if (n > AW'(N_LIMIT))
				n = AW'(N_LIMIT);
			if (k > n)
				return '0;
			if (k * 2 > n)
				k = n - k;
			if (k == 0)
				return CW'(1);
			acc = n;
			for (i = 2; i <= k; i++) begin
				acc = acc * (n - i + 1);
				acc = acc / i;
			end
			return acc[CW-1:0];
		endfunction

		function void note_pair(logic [NW-1:0] n, logic [NW-1:0] k);
			pending_t p;
			p.n    = n;
			p.k    = k;
			p.coef = binomial(n, k);
			expected_q = {expected_q, p};
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task check_coefficient(logic [CW-1:0] got);
			pending_t p;
			if (expected_q.size() == 0) begin
				report($sformatf("coefficient %0d with no transaction outstanding", got));
			end else begin
				p = expected_q.pop_front();
				if (got !== p.coef)
					report($sformatf("C(%0d,%0d): got %0d, expected %0d",
						p.n, p.k, got, p.coef));
			end
		endtask

		task flush_leftovers();
			pending_t p;
			while (expected_q.size() != 0) begin
				p = expected_q.pop_front();
				report($sformatf("C(%0d,%0d) = %0d never came out", p.n, p.k, p.coef));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [NW-1:0] n_total = '0;
	logic [NW-1:0] k_chosen = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CW-1:0] coefficient;

	logic calm_tail = 1'b0;     // set for the final stretch: no idling at all

	coefficient_scoreboard sb = new();

	// corner pairs: saturated n (63), k above n, k zero, k equal to n,
	// the largest coefficients (62 choose 31 and neighbors), folding
	int directed_n [DIR_COUNT] = '{ 0,  0,  0, 62, 62, 62, 62, 63, 63, 63, 63,  1,  1,
		5,  5, 10, 62, 62, 62, 20, 40,  2, 61, 63, 31};
	int directed_k [DIR_COUNT] = '{ 0, 63,  1, 31, 62,  0, 63, 31, 62, 63,  0,  1,  0,
		2,  3,  7,  1, 61, 32, 21, 20,  1, 30,  1, 16};

	binomial_coefficient_unit #(
		.N_MAX(N_LIMIT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.n_total    (n_total),
		.k_chosen   (k_chosen),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coefficient(coefficient)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Input side. Called at a rising edge; raises valid with the pair and
	// holds it until the transaction goes through. Valid is left high so a
	// back-to-back item only rewrites the payload.
	// ------------------------------------------------------------------------
	task send_pair(int n, int k);
		in_valid <= 1'b1;
		n_total  <= n[NW-1:0];
		k_chosen <= k[NW-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_pair(n[NW-1:0], k[NW-1:0]);
	endtask

	// random gap between items, skipped in the calm tail
	task maybe_idle();
		int gap;
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side: checks each completed transaction, then picks out_ready
	// for the next cycle. Stalls come in random bursts.
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_coefficient(coefficient);
			if (calm_tail) begin
				stall_left = 0;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: a long run of cycles with no transaction on either side
	// means the unit has hung.
	// ------------------------------------------------------------------------
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_binomial_coefficient_unit failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int n;
		int k;
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int d = 0; d < DIR_COUNT; d++) begin
			send_pair(directed_n[d], directed_k[d]);
			maybe_idle();
		end

		// mostly small n (few divide rounds), some over the full field
		// range including the saturated n, some with k above n
		for (int r = 0; r < RAND_COUNT; r++) begin
			if (r >= RAND_COUNT - CALM_ITEMS)
				calm_tail = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				n = $urandom_range(0, 20);
				k = $urandom_range(0, n + 2);
			end else if (pick < 90) begin
				n = $urandom_range(0, 63);
				k = $urandom_range(0, 63);
			end else begin
				n = $urandom_range(0, 62);
				k = $urandom_range(n + 1, 63);
			end
			send_pair(n, k);
			maybe_idle();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// anything arriving now is a spurious extra transaction
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftovers();

		if (sb.mismatches == 0)
			$display("tb_binomial_coefficient_unit passed");
		else
			$display("tb_binomial_coefficient_unit failed");
		$finish;
	end

endmodule
